// ===== rtl/pst_pkg.sv =====
// Shared types, constants and codes of the PC sample hit table.
package pst_pkg;

  localparam int unsigned TABLE_SLOTS = 4096;
  localparam int unsigned PROBE_LIMIT = 16;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned PROBE_CW    = $clog2(PROBE_LIMIT + 1);
  localparam int unsigned PC_W        = 64;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned GUEST_W     = 32;
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  // Fibonacci hashing multiplier; only its low SLOT_W bits reach the slot index.
  localparam logic [31:0] HASH_MUL = 32'd2654435761;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALL_THREADS = 1'b0,
    CFG_ONLY_GUEST  = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    REQ_RECORD = 1'b0,
    REQ_READ   = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    OUT_NEW      = 3'd0,
    OUT_INC      = 3'd1,
    OUT_LOST     = 3'd2,
    OUT_OTHER    = 3'd3,
    OUT_FILTERED = 3'd4,
    OUT_READ     = 3'd5
  } outcome_e;

  typedef struct packed {
    logic               req_type;
    logic [PC_W-1:0]    sample_pc;
    logic               on_profiled_thread;
    logic [GUEST_W-1:0] guest_thread;
    logic [IDX_W-1:0]   slot_index;
  } in_t;

  typedef struct packed {
    outcome_e         outcome;
    logic [PC_W-1:0]  entry_pc;
    logic [CNT_W-1:0] entry_hits;
    logic [CNT_W-1:0] total_samples;
    logic [CNT_W-1:0] lost_samples;
    logic [CNT_W-1:0] other_samples;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic     clr_wr;
    logic     accept;
    logic     hash;
    logic     probe;
    logic     take;
    logic     wr;
    logic     rd_slot;
    logic     out_load;
    logic     cnt_other;
    logic     cnt_total;
    logic     cnt_lost;
    outcome_e outcome;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic is_other;
    logic is_filtered;
    logic chk_vld;
    logic chk_empty;
    logic chk_match;
    logic chk_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/pst_dp.sv =====
// Datapath of the PC sample hit table: filters, hash, slot memories, counters, result register.
module pst_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pst_pkg::cmd_t                     cmd_i,
  output pst_pkg::sts_t                     sts_o,
  input  pst_pkg::in_t                      in_data_i,
  input  logic                              cfg_we_i,
  input  logic [pst_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pst_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pst_pkg::out_t                     out_data_o
);
  import pst_pkg::*;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  logic [PC_W-1:0]  pc_mem  [TABLE_SLOTS];
  logic [CNT_W-1:0] hit_mem [TABLE_SLOTS];

  logic               all_threads_q;
  logic [GUEST_W-1:0] only_guest_q;
  in_t                in_q;
  logic [CNT_W-1:0]   total_q, lost_q, other_q;
  logic [SLOT_W-1:0]  clr_addr_q;
  logic [SLOT_W-1:0]  base_q;
  logic [PROBE_CW-1:0] iss_q;
  logic               chk_vld_q, chk_last_q;
  logic [SLOT_W-1:0]  chk_addr_q;
  logic [SLOT_W-1:0]  wr_addr_q;
  logic [CNT_W-1:0]   wr_hits_q;
  logic               wr_new_q;
  logic [CNT_W-1:0]   rd_hits_q;
  logic [PC_W-1:0]    rd_pc_q;
  logic               out_vld_q;
  out_t               out_q, out_d;

  logic [SLOT_W-1:0]   hash_prod;
  logic                iss_ok;
  logic [SLOT_W-1:0]   probe_addr, mem_addr;
  logic                mem_re, hit_we, pc_we;
  logic [CNT_W-1:0]    hit_wdata;

  // only the low SLOT_W bits of the product are needed for the home slot
  assign hash_prod  = in_q.sample_pc[SLOT_W+1:2] * HASH_MUL[SLOT_W-1:0];
  assign iss_ok     = (iss_q < PROBE_CW'(PROBE_LIMIT));
  assign probe_addr = base_q + SLOT_W'(iss_q);

  // filters, evaluated on the incoming transaction
  assign sts_o.is_read     = (in_data_i.req_type == REQ_READ);
  assign sts_o.is_other    = !all_threads_q && !in_data_i.on_profiled_thread;
  assign sts_o.is_filtered = (only_guest_q != '0) && (in_data_i.guest_thread != only_guest_q);
  assign sts_o.clr_last    = (clr_addr_q == SLOT_W'(TABLE_SLOTS - 1));
  assign sts_o.chk_vld     = chk_vld_q;
  assign sts_o.chk_empty   = (rd_hits_q == '0);
  assign sts_o.chk_match   = (rd_pc_q == in_q.sample_pc);
  assign sts_o.chk_last    = chk_last_q;
  assign sts_o.out_free    = !out_vld_q || !out_stall_i;

  always_comb begin
    mem_re    = 1'b0;
    hit_we    = 1'b0;
    pc_we     = 1'b0;
    hit_wdata = wr_hits_q;
    mem_addr  = probe_addr;
    if (cmd_i.clr_wr) begin
      hit_we    = 1'b1;
      hit_wdata = '0;
      mem_addr  = clr_addr_q;
    end else if (cmd_i.wr) begin
      hit_we   = 1'b1;
      pc_we    = wr_new_q;
      mem_addr = wr_addr_q;
    end else if (cmd_i.rd_slot) begin
      mem_re   = 1'b1;
      mem_addr = SLOT_W'(in_q.slot_index);
    end else if (cmd_i.probe) begin
      mem_re = iss_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_we) begin
      hit_mem[mem_addr] <= hit_wdata;
    end else if (mem_re) begin
      rd_hits_q <= hit_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pc_we) begin
      pc_mem[mem_addr] <= in_q.sample_pc;
    end else if (mem_re) begin
      rd_pc_q <= pc_mem[mem_addr];
    end
  end

  always_comb begin
    out_d.outcome       = cmd_i.outcome;
    out_d.entry_pc      = '0;
    out_d.entry_hits    = '0;
    out_d.total_samples = total_q;
    out_d.lost_samples  = lost_q;
    out_d.other_samples = other_q;
    unique case (cmd_i.outcome)
      OUT_NEW, OUT_INC: begin
        out_d.entry_pc   = in_q.sample_pc;
        out_d.entry_hits = wr_hits_q;
      end
      OUT_READ: begin
        out_d.entry_hits = rd_hits_q;
        out_d.entry_pc   = (rd_hits_q != '0) ? rd_pc_q : '0;
      end
      default: begin
        out_d.entry_pc   = '0;
        out_d.entry_hits = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_threads_q <= 1'b0;
      only_guest_q  <= '0;
      total_q       <= '0;
      lost_q        <= '0;
      other_q       <= '0;
      clr_addr_q    <= '0;
      iss_q         <= '0;
      chk_vld_q     <= 1'b0;
      chk_last_q    <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_ALL_THREADS: all_threads_q <= cfg_data_i[0];
          CFG_ONLY_GUEST:  only_guest_q  <= GUEST_W'(cfg_data_i);
          default:         ;
        endcase
      end
      if (cmd_i.cnt_other) other_q <= sat_inc(other_q);
      if (cmd_i.cnt_total) total_q <= sat_inc(total_q);
      if (cmd_i.cnt_lost)  lost_q  <= sat_inc(lost_q);
      if (cmd_i.clr_wr)    clr_addr_q <= clr_addr_q + SLOT_W'(1);
      if (cmd_i.hash) begin
        iss_q     <= '0;
        chk_vld_q <= 1'b0;
      end else if (cmd_i.probe) begin
        chk_vld_q  <= iss_ok;
        chk_last_q <= (iss_q == PROBE_CW'(PROBE_LIMIT - 1));
        if (iss_ok) iss_q <= iss_q + PROBE_CW'(1);
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) in_q <= in_data_i;
    if (cmd_i.hash)   base_q <= hash_prod;
    if (cmd_i.probe)  chk_addr_q <= probe_addr;
    if (cmd_i.take) begin
      wr_addr_q <= chk_addr_q;
      wr_new_q  <= (rd_hits_q == '0);
      wr_hits_q <= (rd_hits_q == '0) ? CNT_W'(1) : sat_inc(rd_hits_q);
    end
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/pst_ctrl.sv =====
// Controller state machine of the PC sample hit table.
module pst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pst_pkg::sts_t sts_i,
  output pst_pkg::cmd_t cmd_o
);
  import pst_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PROBE, S_WRITE, S_READ, S_RESP
  } state_e;

  state_e   state_q, state_d;
  outcome_e outcome_q, outcome_d;
  logic     accept;
  logic     found;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign found      = sts_i.chk_vld && (sts_i.chk_empty || sts_i.chk_match);

  always_comb begin
    state_d       = state_q;
    outcome_d     = outcome_q;
    cmd_o         = '0;
    cmd_o.outcome = outcome_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          priority if (sts_i.is_read) begin
            outcome_d = OUT_READ;
            state_d   = S_READ;
          end else if (sts_i.is_other) begin
            cmd_o.cnt_other = 1'b1;
            outcome_d       = OUT_OTHER;
            state_d         = S_RESP;
          end else if (sts_i.is_filtered) begin
            outcome_d = OUT_FILTERED;
            state_d   = S_RESP;
          end else begin
            cmd_o.cnt_total = 1'b1;
            outcome_d       = OUT_LOST;
            state_d         = S_HASH;
          end
        end
      end
      S_HASH: begin
        cmd_o.hash = 1'b1;
        state_d    = S_PROBE;
      end
      S_PROBE: begin
        cmd_o.probe = 1'b1;
        priority if (found) begin
          cmd_o.take = 1'b1;
          outcome_d  = sts_i.chk_empty ? OUT_NEW : OUT_INC;
          state_d    = S_WRITE;
        end else if (sts_i.chk_vld && sts_i.chk_last) begin
          cmd_o.cnt_lost = 1'b1;
          outcome_d      = OUT_LOST;
          state_d        = S_RESP;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = S_RESP;
      end
      S_READ: begin
        cmd_o.rd_slot = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      outcome_q <= OUT_READ;
    end else begin
      state_q   <= state_d;
      outcome_q <= outcome_d;
    end
  end

endmodule

// ===== rtl/pc_sample_hit_table_core.sv =====
// Top level of the PC sample hit table: controller, datapath and checks.
//
//   channel  direction  handshake                    payload
//   in       input      in_valid_i / in_stall_o      in_data_i  (pst_pkg::in_t)
//   out      output     out_valid_o / out_stall_i    out_data_o (pst_pkg::out_t)
//   cfg      input      cfg_we_i                     cfg_idx_i, cfg_data_i
//
// Transactions are handled one at a time. Filtered and other-thread samples go straight to
// the output register, slot reads pass one slot read first, and samples pass hash, the probe
// loop (up to 16 probes, stopping at the first empty or matching slot) and write-back; lost
// samples end after 16 probes with no write-back. The probe loop runs one read a cycle
// through the single-port slot memories, with the compare in the cycle after the read.
// After reset the hit memory is swept to zero, one slot a cycle, over all 4096 slots; no
// transaction is taken during the sweep (configuration writes still land).
// A finished result waits in the output register while the next transaction is taken in.
module pc_sample_hit_table_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pst_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pst_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [pst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pst_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: clear sweep, filters, hash, probe loop, write-back, result
  pst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot memories, counters, config registers and the output register
  pst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // a chosen slot is always written back on the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.take |=> cmd.wr)
    else $error("slot taken without write-back");

  // a result only appears after the controller loaded it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.out_load))
    else $error("result valid without load");

  // a loaded result is presented on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");

  // memory writes never collide with the probe loop or a slot read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr || cmd.clr_wr) |-> !(cmd.probe || cmd.rd_slot))
    else $error("memory read and write in the same cycle");
`endif

endmodule
